@@ sv/mprst_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mprst_pkg
// shared types, codes and widths of the motor power ramp with sqrt trim
// ----------------------------------------------------------------------------
package mprst_pkg;

    // default parameter values
    localparam int POWER_WIDTH_DEF   = 16;
    localparam int ENCODER_WIDTH_DEF = 16;

    // fixed field widths
    localparam int VAL_W   = 16;             // value field, setpoint register
    localparam int OUT_W   = 16;             // power fields of a result
    localparam int MAG_W   = VAL_W;          // magnitude of setpoint minus measure
    localparam int RT_W    = MAG_W + 1;      // root register of the sqrt unit
    localparam int GAIN_W  = 8;
    localparam int STEP_W  = 15;
    localparam int PROD_W  = RT_W + GAIN_W;
    localparam int ADDR_W  = 5;
    localparam int APB_W   = 32;
    localparam int M_DATA_W = 40;

    // command codes
    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_LOAD = 2'd1;
    localparam logic [1:0] CMD_ENC  = 2'd2;

    // register indexes
    localparam logic [2:0] REG_RAMP_STEP   = 3'd0;
    localparam logic [2:0] REG_TRIM_GAIN   = 3'd1;
    localparam logic [2:0] REG_ENC_SETP    = 3'd2;
    localparam logic [2:0] REG_TRIM_ENABLE = 3'd3;
    localparam logic [2:0] REG_RAMP_HOLD   = 3'd4;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_START = 2'd1,
        PH_UP    = 2'd2,
        PH_DOWN  = 2'd3
    } t_phase;

    // status from the sqrt unit
    typedef struct packed {
        logic            done;
        logic [RT_W-1:0] root;
    } t_sqrt_rsp;

endpackage
`default_nettype wire

@@ sv/mprst_isqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mprst_isqrt
// iterative integer square root, one bit pair per cycle
// ----------------------------------------------------------------------------
module mprst_isqrt #(
    parameter int ENCODER_WIDTH = mprst_pkg::ENCODER_WIDTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [mprst_pkg::MAG_W-1:0] i_mag,
    output mprst_pkg::t_sqrt_rsp             o_rsp
);
    import mprst_pkg::*;

    // trial bits above the magnitude range never succeed, so they are skipped
    localparam int FIRST = 2 * ((ENCODER_WIDTH + 2) / 2);
    localparam int START = (FIRST > MAG_W - 2) ? MAG_W - 2 : FIRST;
    localparam int IDX_W = $clog2(START + 1);

    logic [MAG_W-1:0] r_x;
    logic [RT_W-1:0]  r_res;
    logic [IDX_W-1:0] r_idx;
    logic             r_busy;
    logic             r_done;

    logic [RT_W-1:0]  w_bit;
    logic [RT_W:0]    w_trial;
    logic             w_take;

    assign w_bit   = RT_W'(1) << r_idx;
    assign w_trial = {1'b0, r_res} + {1'b0, w_bit};
    assign w_take  = ((RT_W + 1)'(r_x) >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_x    <= i_mag;
                r_res  <= '0;
                r_idx  <= IDX_W'(START);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (w_take) begin
                    r_x   <= r_x - w_trial[MAG_W-1:0];
                    r_res <= (r_res >> 1) + w_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                if (r_idx == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_idx <= r_idx - IDX_W'(2);
                end
            end
        end
    end

    // done flag above the root
    assign o_rsp = {r_done, r_res};

endmodule
`default_nettype wire

@@ sv/motor_power_ramp_sqrt_trim_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// motor_power_ramp_sqrt_trim_top
// slew-rate limited motor drive power with square-root encoder speed trim
// ----------------------------------------------------------------------------
// One transaction in gives one transaction out showing the state after the
// command. The block works on one command at a time and drops s_axis_tready
// from acceptance until the command is finished. Ramp ticks, target loads,
// refused encoder commands and unused codes pass through S_EXEC and S_DONE,
// where the result register is loaded. An accepted encoder trim runs the
// square-root unit one bit pair per cycle, then a multiply state (S_MUL) and
// a saturating add state (S_TRIM) before S_DONE. The result sits in an
// output register, so a new command is taken while it waits for m_axis_tready.
// Configuration goes through the APB port at byte address 4*index and must
// only be written while no command is in flight.
// ----------------------------------------------------------------------------
module motor_power_ramp_sqrt_trim_top #(
    parameter int POWER_WIDTH   = mprst_pkg::POWER_WIDTH_DEF,
    parameter int ENCODER_WIDTH = mprst_pkg::ENCODER_WIDTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // command stream
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [mprst_pkg::VAL_W-1:0]    s_axis_tdata,  // value
    input  wire logic [1:0]                     s_axis_tuser,  // command
    // result stream
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // power_now, power_target, ramp_phase, saturated, zero pad
    output logic [mprst_pkg::M_DATA_W-1:0]      m_axis_tdata,
    // configuration
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [mprst_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [mprst_pkg::APB_W-1:0]    pwdata,
    output logic [mprst_pkg::APB_W-1:0]         prdata,
    output logic                                pready
);
    import mprst_pkg::*;

    // wide enough for power, step and trim product with room for sign and carry
    localparam int SUM_W = ((POWER_WIDTH > PROD_W + 1) ? POWER_WIDTH : PROD_W + 1) + 2;
    localparam logic signed [SUM_W-1:0] PMAX = SUM_W'({1'b0, {(POWER_WIDTH-1){1'b1}}});
    localparam logic signed [SUM_W-1:0] PMIN = ~PMAX;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SQRT,
        S_MUL,
        S_TRIM,
        S_DONE
    } t_state;

    // configuration registers
    logic [STEP_W-1:0]       r_ramp_step;
    logic [GAIN_W-1:0]       r_trim_gain;
    logic signed [VAL_W-1:0] r_setpoint;
    logic                    r_trim_enable;
    logic                    r_ramp_hold;

    // block state
    t_state                        r_state;
    logic signed [POWER_WIDTH-1:0] r_power;
    logic signed [POWER_WIDTH-1:0] r_target;
    t_phase                        r_phase;
    logic                          r_clip;

    // command being worked on
    logic [1:0]              r_cmd;
    logic signed [VAL_W-1:0] r_val;
    logic                    r_neg;
    logic [PROD_W-1:0]       r_prod;

    // result register
    logic                    r_m_valid;
    logic [M_DATA_W-1:0]     r_m_data;

    // ramp tick
    logic signed [SUM_W-1:0]       w_cur_x;
    logic signed [SUM_W-1:0]       w_tgt_x;
    logic signed [SUM_W-1:0]       w_step_x;
    logic signed [SUM_W-1:0]       w_up_x;
    logic signed [SUM_W-1:0]       w_dn_x;
    logic signed [POWER_WIDTH-1:0] n_tick_power;
    t_phase                        n_tick_phase;

    // load and trim
    logic signed [SUM_W-1:0]       w_val_x;
    logic signed [POWER_WIDTH-1:0] n_load_target;
    logic signed [SUM_W-1:0]       w_trim_x;
    logic signed [POWER_WIDTH-1:0] n_trim_target;
    logic                          n_trim_clip;
    logic signed [MAG_W:0]         w_diff;
    logic signed [MAG_W:0]         w_diff_neg;
    logic [MAG_W-1:0]              w_mag;
    logic                          w_trim_ok;
    logic                          w_sq_start;
    t_sqrt_rsp                     w_sq;

    logic                    w_cfg_wr;

    // ------------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp_step   <= STEP_W'(1);
            r_trim_gain   <= GAIN_W'(1);
            r_setpoint    <= '0;
            r_trim_enable <= 1'b0;
            r_ramp_hold   <= 1'b0;
        end else if (w_cfg_wr) begin
            case (paddr[ADDR_W-1:2])
                REG_RAMP_STEP:   r_ramp_step   <= pwdata[STEP_W-1:0];
                REG_TRIM_GAIN:   r_trim_gain   <= pwdata[GAIN_W-1:0];
                REG_ENC_SETP:    r_setpoint    <= signed'(pwdata[VAL_W-1:0]);
                REG_TRIM_ENABLE: r_trim_enable <= pwdata[0];
                REG_RAMP_HOLD:   r_ramp_hold   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[ADDR_W-1:2])
            REG_RAMP_STEP:   prdata = APB_W'(r_ramp_step);
            REG_TRIM_GAIN:   prdata = APB_W'(r_trim_gain);
            REG_ENC_SETP:    prdata = APB_W'(unsigned'(r_setpoint));
            REG_TRIM_ENABLE: prdata = APB_W'(r_trim_enable);
            REG_RAMP_HOLD:   prdata = APB_W'(r_ramp_hold);
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // ramp tick: one step toward the target, held at zero on a sign change
    // ------------------------------------------------------------------------
    always_comb begin
        w_cur_x  = SUM_W'(r_power);
        w_tgt_x  = SUM_W'(r_target);
        // a zero step behaves as one
        w_step_x = signed'(SUM_W'((r_ramp_step == '0) ? STEP_W'(1) : r_ramp_step));
        w_up_x   = w_cur_x + w_step_x;
        w_dn_x   = w_cur_x - w_step_x;
        n_tick_power = r_power;
        n_tick_phase = r_phase;
        if (r_phase != PH_IDLE && !r_ramp_hold) begin
            if (r_phase == PH_START && w_tgt_x == w_cur_x) begin
                n_tick_phase = PH_IDLE;
            end else if ((r_phase == PH_START && w_tgt_x > w_cur_x) || r_phase == PH_UP) begin
                if (w_up_x >= w_tgt_x) begin
                    n_tick_power = r_target;
                    n_tick_phase = PH_IDLE;
                end else begin
                    n_tick_phase = PH_UP;
                    n_tick_power = (w_cur_x < 0 && w_up_x > 0) ? '0 : w_up_x[POWER_WIDTH-1:0];
                end
            end else begin
                if (w_dn_x <= w_tgt_x) begin
                    n_tick_power = r_target;
                    n_tick_phase = PH_IDLE;
                end else begin
                    n_tick_phase = PH_DOWN;
                    n_tick_power = (w_cur_x > 0 && w_dn_x < 0) ? '0 : w_dn_x[POWER_WIDTH-1:0];
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // target load and trim, both clamped to the power range
    // ------------------------------------------------------------------------
    always_comb begin
        w_val_x = SUM_W'(r_val);
        if (w_val_x > PMAX) begin
            n_load_target = PMAX[POWER_WIDTH-1:0];
        end else if (w_val_x < PMIN) begin
            n_load_target = PMIN[POWER_WIDTH-1:0];
        end else begin
            n_load_target = w_val_x[POWER_WIDTH-1:0];
        end

        w_trim_x    = r_neg ? (w_tgt_x - signed'(SUM_W'(r_prod)))
                            : (w_tgt_x + signed'(SUM_W'(r_prod)));
        n_trim_clip = 1'b1;
        if (w_trim_x > PMAX) begin
            n_trim_target = PMAX[POWER_WIDTH-1:0];
        end else if (w_trim_x < PMIN) begin
            n_trim_target = PMIN[POWER_WIDTH-1:0];
        end else begin
            n_trim_target = w_trim_x[POWER_WIDTH-1:0];
            n_trim_clip   = 1'b0;
        end
    end

    // encoder error and its magnitude for the root unit
    assign w_diff     = (MAG_W + 1)'(r_setpoint) - (MAG_W + 1)'(r_val);
    assign w_diff_neg = -w_diff;
    assign w_mag      = w_diff[MAG_W] ? w_diff_neg[MAG_W-1:0] : w_diff[MAG_W-1:0];
    assign w_trim_ok  = r_trim_enable && (r_phase == PH_IDLE);
    assign w_sq_start = (r_state == S_EXEC) && (r_cmd == CMD_ENC) && w_trim_ok;

    mprst_isqrt #(
        .ENCODER_WIDTH (ENCODER_WIDTH)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_mag   (w_mag),
        .o_rsp   (w_sq)
    );

    // ------------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_power   <= '0;
            r_target  <= '0;
            r_phase   <= PH_IDLE;
            r_clip    <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_cmd   <= s_axis_tuser;
                        r_val   <= signed'(s_axis_tdata);
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_clip <= 1'b0;
                    case (r_cmd)
                        CMD_TICK: begin
                            r_power <= n_tick_power;
                            r_phase <= n_tick_phase;
                            r_state <= S_DONE;
                        end
                        CMD_LOAD: begin
                            r_target <= n_load_target;
                            r_phase  <= PH_START;
                            r_state  <= S_DONE;
                        end
                        CMD_ENC: begin
                            // refused unless trim is on and the ramp is idle
                            r_neg   <= w_diff[MAG_W];
                            r_state <= w_trim_ok ? S_SQRT : S_DONE;
                        end
                        default: r_state <= S_DONE;
                    endcase
                end
                S_SQRT: begin
                    if (w_sq.done) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= PROD_W'(w_sq.root) * PROD_W'(r_trim_gain);
                    r_state <= S_TRIM;
                end
                S_TRIM: begin
                    r_target <= n_trim_target;
                    r_clip   <= n_trim_clip;
                    r_phase  <= PH_START;
                    r_state  <= S_DONE;
                end
                S_DONE: begin
                    // wait for the result register to be free
                    if (!r_m_valid || m_axis_tready) begin
                        r_m_data  <= {(M_DATA_W - 2*OUT_W - 3)'(0), r_clip,
                                      2'(r_phase), w_tgt_x[OUT_W-1:0], w_cur_x[OUT_W-1:0]};
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            // result register: filled when a command finishes, emptied on a transfer
            if (r_state == S_DONE && (!r_m_valid || m_axis_tready)) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule
`default_nettype wire

@@ sv/mprst_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mprst_checker
// port-level checks of the motor power ramp, bound to the top level
// ----------------------------------------------------------------------------
module mprst_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           s_axis_tvalid,
    input wire logic                           s_axis_tready,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [mprst_pkg::M_DATA_W-1:0] m_axis_tdata
);
    import mprst_pkg::*;

    logic [1:0] w_phase;
    assign w_phase = m_axis_tdata[2*OUT_W+1:2*OUT_W];

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // one command at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("command accepted while busy");

    // clipping is only reported by a trim, which restarts the ramp
    a_clip_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[2*OUT_W+2] |-> w_phase == 2'(PH_START))
        else $error("saturated without a ramp restart");

    // an idle ramp sits on its target
    a_idle_on_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_phase == 2'(PH_IDLE)
        |-> m_axis_tdata[OUT_W-1:0] == m_axis_tdata[2*OUT_W-1:OUT_W])
        else $error("idle ramp away from target");

endmodule

bind motor_power_ramp_sqrt_trim_top mprst_checker u_mprst_checker (.*);
`default_nettype wire
